// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KMC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kmc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define KMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kmc assertion failed");

`endif

// ===== src/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg
// Types and constants shared by the key matrix change encoder.
// ----------------------------------------------------------------------------
package kmc_pkg;

	// Field widths
	localparam int ROW_W    = 4;
	localparam int BITS_W   = 6;
	localparam int F7_W     = 7;
	localparam int ADDR_W   = 2;
	localparam int MAX_COLS = 8;
	localparam int COL_W    = 3;
	localparam int KEY_W    = 8;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_BASE_NOTE   = 2'd0;
	localparam logic [ADDR_W-1:0] REG_HIGHEST_KEY = 2'd1;
	localparam logic [ADDR_W-1:0] REG_ON_VELOCITY = 2'd2;

	// Reset values and limits
	localparam logic [F7_W-1:0] BASE_NOTE_RST   = 7'd48;
	localparam logic [F7_W-1:0] HIGHEST_KEY_RST = 7'd60;
	localparam logic [F7_W-1:0] ON_VELOCITY_RST = 7'd127;
	localparam logic [F7_W-1:0] NOTE_MAX        = 7'd127;

	typedef struct packed {
		logic [F7_W-1:0] base_note;
		logic [F7_W-1:0] highest_key;
		logic [F7_W-1:0] on_velocity;
	} cfg_regs_t;

	// One row's worth of changes handed to the serializer
	typedef struct packed {
		logic                 vld;
		logic [KEY_W-1:0]     key_base;
		logic [MAX_COLS-1:0]  changed;
		logic [MAX_COLS-1:0]  bits;
	} ser_load_t;

endpackage

// ===== src/kmc_if.sv =====
// ----------------------------------------------------------------------------
// kmc_if
// Channel interfaces: scanned rows in, note messages out, register writes.
// ----------------------------------------------------------------------------
interface kmc_scan_if;
	logic       valid;
	logic       ready;
	logic [3:0] row;
	logic [5:0] column_bits;

	modport source (output valid, row, column_bits, input ready);
	modport sink   (input valid, row, column_bits, output ready);
endinterface

interface kmc_msg_if;
	logic       valid;
	logic       ready;
	logic [6:0] note;
	logic [6:0] velocity;
	logic       last;

	modport source (output valid, note, velocity, last, input ready);
	modport sink   (input valid, note, velocity, last, output ready);
endinterface

interface kmc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] addr;
	logic [6:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

// ===== src/kmc_row_mem.sv =====
// ----------------------------------------------------------------------------
// kmc_row_mem
// Previous-row store: one entry per matrix row, registered read, per-entry
// valid bits so that unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module kmc_row_mem #(
	parameter int ROWS = 11,
	parameter int COLS = 6
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         rd_en,
	input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0]   rd_addr,
	output logic [COLS-1:0]                              rd_data,
	input  logic                                         wr_en,
	input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0]   wr_addr,
	input  logic [COLS-1:0]                              wr_data
);
	logic [COLS-1:0] mem_q [ROWS];
	logic [ROWS-1:0] row_vld_q;
	logic [COLS-1:0] rd_data_q;

	// Valid bits: cleared by reset, set on first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read; an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= row_vld_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== src/kmc_serializer.sv =====
// ----------------------------------------------------------------------------
// kmc_serializer
// Walks the changed-column mask of one row lowest column first and puts
// one note message per cycle into the output register while msg is not stalled.
// ----------------------------------------------------------------------------
module kmc_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  kmc_pkg::cfg_regs_t cfg_regs,
	input  kmc_pkg::ser_load_t load,
	output logic               load_ready,
	kmc_msg_if.source          msg
);
	import kmc_pkg::*;

	logic [MAX_COLS-1:0] pend_q;
	logic [MAX_COLS-1:0] bits_q;
	logic [KEY_W-1:0]    key_base_q;
	logic                out_vld_q;
	logic [F7_W-1:0]     note_q;
	logic [F7_W-1:0]     vel_q;
	logic                last_q;

	logic                emit;
	logic [COL_W-1:0]    col;
	logic [MAX_COLS-1:0] pend_rest;
	logic [KEY_W-1:0]    key;
	logic [KEY_W:0]      note_sum;
	logic [F7_W-1:0]     note_nxt;
	logic [F7_W-1:0]     vel_nxt;

	// Lowest pending column
	always_comb begin
		col = '0;
		for (int i = MAX_COLS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				col = COL_W'(i);
			end
		end
	end

	assign pend_rest  = pend_q & (pend_q - MAX_COLS'(1));
	assign emit       = (|pend_q) && (!out_vld_q || msg.ready);
	assign load_ready = (pend_q == '0) || (emit && (pend_rest == '0));

	// Note: base plus key index, clamped; unmapped keys give zero
	assign key      = key_base_q + KEY_W'(col);
	assign note_sum = (KEY_W + 1)'(cfg_regs.base_note) + (KEY_W + 1)'(key);
	always_comb begin
		priority if (key > KEY_W'(cfg_regs.highest_key)) begin
			note_nxt = '0;
		end else if (note_sum > (KEY_W + 1)'(NOTE_MAX)) begin
			note_nxt = NOTE_MAX;
		end else begin
			note_nxt = note_sum[F7_W-1:0];
		end
	end
	assign vel_nxt = bits_q[col] ? cfg_regs.on_velocity : '0;

	// Pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load.vld) begin
			pend_q <= load.changed;
		end else if (emit) begin
			pend_q <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load.vld) begin
			bits_q     <= load.bits;
			key_base_q <= load.key_base;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (msg.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			note_q <= note_nxt;
			vel_q  <= vel_nxt;
			last_q <= (pend_rest == '0);
		end
	end

	assign msg.valid    = out_vld_q;
	assign msg.note     = note_q;
	assign msg.velocity = vel_q;
	assign msg.last     = last_q;
endmodule

// ===== src/key_matrix_midi_change_encoder.sv =====
// ----------------------------------------------------------------------------
// key_matrix_midi_change_encoder
// Compares each scanned matrix row with its stored previous bits and sends
// one running-status note message per changed key, lowest column first.
// ----------------------------------------------------------------------------
//  channel | dir | request                          | handshake
//  scan    | in  | row, column_bits                 | valid/ready
//  msg     | out | note, velocity, last             | valid/ready
//  cfg     | in  | addr (register index), data      | valid/ready, ready tied high
//
//  A row occupies the serializer for one message per changed key, one message per
//  cycle while msg is not stalled; a row with no change or an out-of-range row
//  never reaches the serializer. A message passes through vld_s1, the pending
//  mask and the output register. Row store read is registered; the last write is
//  forwarded to a following request for the same row. Reset clears the store's
//  valid bits at once. A stalled msg holds its message and backs up into scan.ready.
// ----------------------------------------------------------------------------
module key_matrix_midi_change_encoder #(
	parameter int ROWS = 11,
	parameter int COLS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	kmc_scan_if.sink  scan,
	kmc_msg_if.source msg,
	kmc_cfg_if.sink   cfg
);
	import kmc_pkg::*;

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	cfg_regs_t           cfg_q;
	logic                vld_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [COLS-1:0]     bits_s1;
	logic                fwd_vld_q;
	logic [ROW_W-1:0]    fwd_row_q;
	logic [COLS-1:0]     fwd_bits_q;

	logic                in_range;
	logic                accept;
	logic [MAX_COLS-1:0] bits_ext;
	logic [COLS-1:0]     rd_data;
	logic [COLS-1:0]     prev_bits;
	logic [COLS-1:0]     changed;
	logic                s1_adv;
	logic                ser_ready;
	ser_load_t           ser_load;

	// Configuration registers; writes beyond the list are dropped
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_note   <= BASE_NOTE_RST;
			cfg_q.highest_key <= HIGHEST_KEY_RST;
			cfg_q.on_velocity <= ON_VELOCITY_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_BASE_NOTE:   cfg_q.base_note   <= cfg.data;
				REG_HIGHEST_KEY: cfg_q.highest_key <= cfg.data;
				REG_ON_VELOCITY: cfg_q.on_velocity <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input stage: out-of-range rows are taken and dropped
	assign in_range   = {1'b0, scan.row} < (ROW_W + 1)'(ROWS);
	assign bits_ext   = MAX_COLS'(scan.column_bits);
	assign scan.ready = !vld_s1 || s1_adv;
	assign accept     = scan.valid && scan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= in_range;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1  <= scan.row;
			bits_s1 <= bits_ext[COLS-1:0];
		end
	end

	// Previous row store
	kmc_row_mem #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (scan.row[RW-1:0]),
		.rd_data (rd_data),
		.wr_en   (s1_adv),
		.wr_addr (row_s1[RW-1:0]),
		.wr_data (bits_s1)
	);

	// Forward the most recent write over the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (s1_adv) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fwd_row_q  <= row_s1;
			fwd_bits_q <= bits_s1;
		end
	end

	assign prev_bits = (fwd_vld_q && (fwd_row_q == row_s1)) ? fwd_bits_q : rd_data;
	assign changed   = bits_s1 ^ prev_bits;

	// Stage 1 retires when unchanged or once the serializer can take it
	assign s1_adv = vld_s1 && ((changed == '0) || ser_ready);

	assign ser_load.vld      = s1_adv && (changed != '0);
	assign ser_load.key_base = KEY_W'(row_s1) * KEY_W'(COLS);
	assign ser_load.changed  = MAX_COLS'(changed);
	assign ser_load.bits     = MAX_COLS'(bits_s1);

	kmc_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_q),
		.load       (ser_load),
		.load_ready (ser_ready),
		.msg        (msg)
	);
endmodule

// ===== src/kmc_checker.sv =====
// ----------------------------------------------------------------------------
// kmc_checker
// Port-level checks on the key matrix change encoder, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_ready,
	input logic [6:0] msg_note,
	input logic [6:0] msg_velocity,
	input logic       msg_last,
	input logic       cfg_ready
);
	// A stalled message stays offered
	`KMC_ASSERT_NEXT(a_msg_hold, clk, arst_n, msg_valid && !msg_ready, msg_valid)

	// A stalled message keeps its fields
	`KMC_ASSERT_NEXT(a_msg_stable, clk, arst_n, msg_valid && !msg_ready, $stable({msg_note, msg_velocity, msg_last}))

	// Messages of one row follow back to back once the first is taken
	`KMC_ASSERT_NEXT(a_run_cont, clk, arst_n, msg_valid && msg_ready && !msg_last, msg_valid)

	// Register writes are never refused
	`KMC_ASSERT_IMPLY(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)
endmodule

bind key_matrix_midi_change_encoder kmc_checker u_kmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_valid    (msg.valid),
	.msg_ready    (msg.ready),
	.msg_note     (msg.note),
	.msg_velocity (msg.velocity),
	.msg_last     (msg.last),
	.cfg_ready    (cfg.ready)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key matrix change encoder. Scanned rows are
// sent through the scan channel, and a local model of the row store predicts
// the note messages for every accepted request. The model also covers the
// clamping of notes, unmapped keys and the register values. Each message is
// checked field by field in order. Runs go through several register settings
// and several patterns of source and sink idling, with one long sink stall.
// ----------------------------------------------------------------------------
module tb_top;
	import kmc_pkg::*;

	localparam int NUM_ROWS       = 11;
	localparam int NUM_COLS       = 6;
	localparam int ROW_CODE_MAX   = (1 << ROW_W) - 1;
	localparam int COLS_CODE_MAX  = (1 << BITS_W) - 1;
	localparam int SETTLE_CYCLES  = 12;
	localparam int SINK_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRINT_CAP      = 40;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [BITS_W-1:0] cols;
	} row_req_t;

	typedef struct packed {
		logic [F7_W-1:0] note;
		logic [F7_W-1:0] velocity;
		logic            last;
	} note_msg_t;

	logic clk;
	logic arst_n;

	kmc_scan_if scan ();
	kmc_msg_if  msg ();
	kmc_cfg_if  cfg ();

	key_matrix_midi_change_encoder #(
		.ROWS(NUM_ROWS),
		.COLS(NUM_COLS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.scan  (scan),
		.msg   (msg),
		.cfg   (cfg)
	);

	// Rows waiting to be sent, and notes waiting to come out
	row_req_t  rows_to_send[$];
	note_msg_t due_notes[$];
	row_req_t  next_row;
	note_msg_t next_due;

	// Local copy of the row store and registers
	logic [BITS_W-1:0] stored_cols [NUM_ROWS] = '{default: '0};
	logic [F7_W-1:0]   cfg_base_note   = BASE_NOTE_RST;
	logic [F7_W-1:0]   cfg_highest_key = HIGHEST_KEY_RST;
	logic [F7_W-1:0]   cfg_on_velocity = ON_VELOCITY_RST;

	// Row contents as planned at queueing time, used to shape stimulus
	logic [BITS_W-1:0] planned_cols [NUM_ROWS] = '{default: '0};

	int rows_queued   = 0;
	int rows_accepted = 0;
	int fail_count    = 0;
	int quiet_cycles  = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Long sink stall, armed once
	logic hold_armed = 1'b0;
	logic hold_done  = 1'b0;
	int   hold_at    = 0;
	int   hold_left  = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void predict_key_changes(input logic [ROW_W-1:0] row_idx,
		input logic [BITS_W-1:0] cols);
		logic [BITS_W-1:0] flipped;
		note_msg_t         m;
		int                key;
		int                pitch;
		if (row_idx >= NUM_ROWS) begin
			return;
		end
		flipped = cols ^ stored_cols[row_idx];
		stored_cols[row_idx] = cols;
		for (int c = 0; c < NUM_COLS; c++) begin
			if (flipped[c]) begin
				key   = row_idx * NUM_COLS + c;
				pitch = cfg_base_note + key;
				if (key > cfg_highest_key) begin
					m.note = '0;
				end else if (pitch > NOTE_MAX) begin
					m.note = NOTE_MAX;
				end else begin
					m.note = pitch[F7_W-1:0];
				end
				m.velocity = cols[c] ? cfg_on_velocity : '0;
				// last on the highest changed column
				m.last = ((flipped >> (c + 1)) == 0);
				due_notes.push_back(m);
			end
		end
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endtask

	task automatic queue_row(input logic [ROW_W-1:0] row_idx, input logic [BITS_W-1:0] cols);
		row_req_t req;
		req.row  = row_idx;
		req.cols = cols;
		rows_to_send.push_back(req);
		rows_queued++;
		if (row_idx < NUM_ROWS) begin
			planned_cols[row_idx] = cols;
		end
	endtask

	// Mostly real key activity; some repeats, single-key flips and bad rows
	task automatic queue_random_rows(input int count);
		int                made;
		int                pick;
		logic [ROW_W-1:0]  r;
		logic [BITS_W-1:0] b;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				queue_row(ROW_W'($urandom_range(NUM_ROWS, ROW_CODE_MAX)),
					BITS_W'($urandom_range(0, COLS_CODE_MAX)));
			end else begin
				r = ROW_W'($urandom_range(0, NUM_ROWS - 1));
				if (pick < 18) begin
					b = planned_cols[r];
				end else if (pick < 32) begin
					b = planned_cols[r] ^ BITS_W'(1 << $urandom_range(0, NUM_COLS - 1));
				end else begin
					b = BITS_W'($urandom_range(0, COLS_CODE_MAX));
				end
				queue_row(r, b);
				made++;
			end
		end
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [F7_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.addr  <= idx;
		cfg.data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [F7_W-1:0] base, input logic [F7_W-1:0] top_key,
		input logic [F7_W-1:0] vel);
		write_reg(REG_BASE_NOTE, base);
		write_reg(REG_HIGHEST_KEY, top_key);
		write_reg(REG_ON_VELOCITY, vel);
	endtask

	// Wait until every row is taken and every note has come out
	task automatic drain();
		do begin
			@(posedge clk);
		end while (rows_accepted != rows_queued || due_notes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Scan request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			scan.valid       <= 1'b0;
			scan.row         <= '0;
			scan.column_bits <= '0;
		end else begin
			if (!scan.valid || scan.ready) begin
				if (rows_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_row = rows_to_send.pop_front();
					scan.valid       <= 1'b1;
					scan.row         <= next_row.row;
					scan.column_bits <= next_row.cols;
				end else begin
					scan.valid <= 1'b0;
				end
			end
		end
	end

	// Message sink: random idling, plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			msg.ready <= 1'b0;
		end else begin
			if (hold_left != 0) begin
				msg.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_armed && !hold_done && rows_accepted >= hold_at) begin
				msg.ready <= 1'b0;
				hold_left <= SINK_HOLD;
				hold_done <= 1'b1;
			end else begin
				msg.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Monitor: register writes, accepted rows, and message checks
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					REG_BASE_NOTE: begin
						cfg_base_note = cfg.data;
					end
					REG_HIGHEST_KEY: begin
						cfg_highest_key = cfg.data;
					end
					REG_ON_VELOCITY: begin
						cfg_on_velocity = cfg.data;
					end
					default: begin
					end
				endcase
			end
			if (scan.valid && scan.ready) begin
				predict_key_changes(scan.row, scan.column_bits);
				rows_accepted <= rows_accepted + 1;
			end
			if (msg.valid && msg.ready) begin
				if (due_notes.size() == 0) begin
					report_mismatch($sformatf("unexpected note %0d velocity %0d last %0d",
						msg.note, msg.velocity, msg.last));
				end else begin
					next_due = due_notes.pop_front();
					if (msg.note !== next_due.note) begin
						report_mismatch($sformatf("note: expected %0d, got %0d",
							next_due.note, msg.note));
					end
					if (msg.velocity !== next_due.velocity) begin
						report_mismatch($sformatf("velocity: expected %0d, got %0d",
							next_due.velocity, msg.velocity));
					end
					if (msg.last !== next_due.last) begin
						report_mismatch($sformatf("last: expected %0d, got %0d",
							next_due.last, msg.last));
					end
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((scan.valid && scan.ready) || (msg.valid && msg.ready) || (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Reset, register settings and stimulus phases
	initial begin
		arst_n    = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr  = '0;
		cfg.data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values; source idles lightly, sink heavily
		send_idle_pct = 37;
		recv_idle_pct = 88;
		queue_row(0, 6'b000000);
		queue_row(0, 6'b111111);
		queue_row(0, 6'b111111);
		queue_row(0, 6'b000000);
		queue_row(10, 6'b111111);
		queue_row(10, 6'b000000);
		queue_row(11, 6'b111111);
		queue_row(15, 6'b010101);
		queue_row(12, 6'b101010);
		queue_row(5, 6'b101010);
		queue_row(5, 6'b010101);
		queue_row(9, 6'b100000);
		queue_row(9, 6'b000001);
		queue_row(1, 6'b000001);
		queue_row(2, 6'b000010);
		queue_row(3, 6'b000100);
		queue_row(4, 6'b001000);
		queue_row(6, 6'b010000);
		queue_row(7, 6'b100000);
		queue_row(8, 6'b111111);
		queue_row(8, 6'b111111);
		queue_random_rows(20);
		drain();

		// Every key mapped, all notes clamp, lowest on velocity
		write_all_regs(7'd127, 7'd65, 7'd1);
		queue_row(0, ~planned_cols[0]);
		queue_row(10, ~planned_cols[10]);
		queue_random_rows(24);
		drain();

		// Only key zero mapped, zero on velocity; source idles heavily now
		send_idle_pct = 88;
		recv_idle_pct = 37;
		write_all_regs(7'd0, 7'd0, 7'd0);
		queue_row(0, ~planned_cols[0]);
		queue_row(10, ~planned_cols[10]);
		queue_random_rows(24);
		drain();

		// Random register values
		write_all_regs(F7_W'($urandom_range(0, 127)), F7_W'($urandom_range(0, 65)),
			F7_W'($urandom_range(1, 127)));
		queue_random_rows(25);
		drain();

		// No idling, with a long sink stall so the scan side backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all_regs(7'd60, 7'd30, 7'd100);
		hold_at    = rows_accepted + 6;
		hold_armed = 1'b1;
		queue_random_rows(30);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/kmc_pkg.sv
src/kmc_if.sv
src/kmc_row_mem.sv
src/kmc_serializer.sv
src/key_matrix_midi_change_encoder.sv
src/kmc_checker.sv
tb/tb_top.sv
